// ===== src/hcbd_pkg.sv =====
package hcbd_pkg;

    // Field and port widths
    localparam int KEY_W   = 8;
    localparam int LEN_W   = 4;
    localparam int CFG_W   = 40;
    localparam int HIGH_W  = 32;
    localparam int IDX_W   = 2;
    localparam int CIPH_W  = 20;
    localparam int PLAIN_W = 8;
    localparam int LANES   = 3;
    localparam int KEYS    = 9;
    localparam int LOW_KEYS = 5;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

    localparam logic [LEN_W-1:0] KEY_SMALL_MAX = 4'd4;
    localparam logic [LEN_W-1:0] KEY_LARGE_MAX = 4'd9;

    // Arithmetic widths, sized from the byte and ciphertext ranges
    localparam int ADJ_W  = 18;
    localparam int DET_W  = 28;
    localparam int PROD_W = 39;
    localparam int NUM_W  = 40;
    localparam int AN_W   = 38;
    localparam int AD_W   = 26;
    localparam int N_W    = AN_W + 1;
    localparam int D_W    = AD_W + 1;
    localparam int DIV_STEPS = N_W;

    // Queue between front and back
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;
    localparam int FCNT_W = 2;

    typedef struct packed {
        logic [LANES-1:0][AN_W-1:0] an;
        logic [LANES-1:0]           neg;
        logic [AD_W-1:0]            ad;
        logic                       sing;
        logic                       last;
    } q_entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_stat_t;

endpackage

// ===== src/hcbd_front.sv =====
module hcbd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [hcbd_pkg::IDX_W-1:0] cfg_index,
    input  logic [hcbd_pkg::CFG_W-1:0] cfg_data,
    input  logic                      take,
    input  logic [hcbd_pkg::CIPH_W-1:0] c0,
    input  logic [hcbd_pkg::CIPH_W-1:0] c1,
    input  logic [hcbd_pkg::CIPH_W-1:0] c2,
    input  logic                      last,
    output logic                      push,
    output hcbd_pkg::q_entry_t        entry,
    output logic [hcbd_pkg::FCNT_W-1:0] front_cnt
);
    import hcbd_pkg::*;

    logic [LEN_W-1:0]  len_reg;
    logic [CFG_W-1:0]  low_reg;
    logic [HIGH_W-1:0] high_reg;

    logic [LEN_W-1:0] len_sat;
    logic             mode3;
    logic signed [KEY_W:0] m [KEYS];
    logic signed [ADJ_W-1:0] adj [KEYS];
    logic signed [ADJ_W-1:0] det2;

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [ADJ_W-1:0] adj1_reg [KEYS];
    logic signed [ADJ_W-1:0] det1_reg;
    logic signed [KEY_W:0]   m1_reg [LANES];
    logic [CIPH_W-1:0]       c1_reg [LANES];
    logic                    last1_reg, mode1_reg;

    logic signed [PROD_W-1:0] prod2_reg [KEYS];
    logic signed [DET_W-1:0]  det2_reg;
    logic                     last2_reg;

    logic signed [NUM_W-1:0] num [LANES];
    q_entry_t                e3_next, e3_reg;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            low_reg  <= '0;
            high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_LENGTH: len_reg  <= cfg_data[LEN_W-1:0];
                REG_KEY_LOW:    low_reg  <= cfg_data;
                REG_KEY_HIGH:   high_reg <= cfg_data[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Build key matrix and its adjugate
    always_comb
    begin
        len_sat = (len_reg > KEY_LARGE_MAX) ? KEY_LARGE_MAX : len_reg;
        mode3   = len_sat > KEY_SMALL_MAX;
        for (int i = 0; i < LOW_KEYS; i++)
            m[i] = (LEN_W'(i) < len_sat) ? $signed({1'b0, low_reg[8*i +: KEY_W]}) : '0;
        for (int i = LOW_KEYS; i < KEYS; i++)
            m[i] = (LEN_W'(i) < len_sat) ?
                   $signed({1'b0, high_reg[8*(i-LOW_KEYS) +: KEY_W]}) : '0;
        det2 = ADJ_W'(m[0] * m[3] - m[1] * m[2]);
        if (mode3)
        begin
            adj[0] = ADJ_W'(m[4] * m[8] - m[5] * m[7]);
            adj[1] = ADJ_W'(m[2] * m[7] - m[1] * m[8]);
            adj[2] = ADJ_W'(m[1] * m[5] - m[2] * m[4]);
            adj[3] = ADJ_W'(m[5] * m[6] - m[3] * m[8]);
            adj[4] = ADJ_W'(m[0] * m[8] - m[2] * m[6]);
            adj[5] = ADJ_W'(m[2] * m[3] - m[0] * m[5]);
            adj[6] = ADJ_W'(m[3] * m[7] - m[4] * m[6]);
            adj[7] = ADJ_W'(m[1] * m[6] - m[0] * m[7]);
            adj[8] = ADJ_W'(m[0] * m[4] - m[1] * m[3]);
        end
        else
        begin
            // 2x2 adjugate laid into the 3x3 slots, third column and row zero
            for (int i = 0; i < KEYS; i++)
                adj[i] = '0;
            adj[0] = ADJ_W'(m[3]);
            adj[3] = ADJ_W'(-m[2]);
            adj[1] = ADJ_W'(-m[1]);
            adj[4] = ADJ_W'(m[0]);
        end
    end

    // Sum lanes, take magnitudes and signs
    always_comb
    begin
        e3_next.ad   = AD_W'(det2_reg < 0 ? -det2_reg : det2_reg);
        e3_next.sing = (det2_reg == '0);
        e3_next.last = last2_reg;
        for (int k = 0; k < LANES; k++)
        begin
            num[k] = NUM_W'(prod2_reg[k]) + NUM_W'(prod2_reg[3+k]) + NUM_W'(prod2_reg[6+k]);
            e3_next.neg[k] = (num[k] < 0) ^ (det2_reg < 0);
            e3_next.an[k]  = AN_W'(num[k] < 0 ? -num[k] : num[k]);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEYS; i++)
            adj1_reg[i] <= adj[i];
        det1_reg  <= det2;
        m1_reg[0] <= m[0];
        m1_reg[1] <= m[1];
        m1_reg[2] <= m[2];
        c1_reg[0] <= c0;
        c1_reg[1] <= c1;
        c1_reg[2] <= c2;
        last1_reg <= last;
        mode1_reg <= mode3;

        for (int j = 0; j < LANES; j++)
            for (int k = 0; k < LANES; k++)
                prod2_reg[3*j+k] <= PROD_W'(adj1_reg[3*j+k] * $signed({1'b0, c1_reg[j]}));
        det2_reg  <= mode1_reg ?
                     DET_W'(m1_reg[0] * adj1_reg[0] + m1_reg[1] * adj1_reg[3]
                            + m1_reg[2] * adj1_reg[6]) :
                     DET_W'(det1_reg);
        last2_reg <= last1_reg;

        e3_reg <= e3_next;
    end

    assign push      = v3_reg;
    assign entry     = e3_reg;
    assign front_cnt = FCNT_W'({1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg});

endmodule

// ===== src/hcbd_fifo.sv =====
module hcbd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hcbd_pkg::q_entry_t wdata,
    input  logic               pop,
    output hcbd_pkg::q_entry_t rdata,
    output hcbd_pkg::q_stat_t  stat
);
    import hcbd_pkg::*;

    q_entry_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // Write entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    // Move pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    assign rdata      = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);

endmodule

// ===== src/hcbd_back.sv =====
module hcbd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hcbd_pkg::q_entry_t          head,
    input  hcbd_pkg::q_stat_t           stat,
    output logic                        pop,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [hcbd_pkg::PLAIN_W-1:0] plain_first,
    output logic [hcbd_pkg::PLAIN_W-1:0] plain_second,
    output logic [hcbd_pkg::PLAIN_W-1:0] plain_third,
    output logic                        singular_key,
    output logic                        last_out
);
    import hcbd_pkg::*;

    typedef struct packed {
        logic [LANES-1:0][N_W-1:0]     n;
        logic [LANES-1:0][D_W-1:0]     rem;
        logic [LANES-1:0][PLAIN_W-1:0] q;
        logic [LANES-1:0]              neg;
        logic [D_W-1:0]                d;
        logic                          sing;
        logic                          last;
    } div_t;

    div_t                 stg_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0]   vld_reg;
    div_t                 load;
    logic                 en;
    logic                 out_valid_reg;
    logic [PLAIN_W-1:0]   p_reg [LANES];
    logic                 sing_reg, last_reg;

    assign en  = !(out_valid_reg && out_stall);
    assign pop = en && !stat.empty;

    // Form rounded-quotient operands: (2|n| + |d|) / (2|d|)
    always_comb
    begin
        load.d    = {head.ad, 1'b0};
        load.sing = head.sing;
        load.last = head.last;
        load.neg  = head.neg;
        for (int k = 0; k < LANES; k++)
        begin
            load.n[k]   = {head.an[k], 1'b0} + N_W'(head.ad);
            load.rem[k] = '0;
            load.q[k]   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stg_reg[0] <= load;
    end

    // One quotient bit per stage, restoring
    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        div_t         nxt;
        logic [D_W:0] sh [LANES];

        always_comb
        begin
            nxt = stg_reg[s];
            for (int l = 0; l < LANES; l++)
            begin
                sh[l] = {stg_reg[s].rem[l], stg_reg[s].n[l][N_W-1-s]};
                if (sh[l] >= {1'b0, stg_reg[s].d})
                begin
                    nxt.rem[l] = D_W'(sh[l] - {1'b0, stg_reg[s].d});
                    nxt.q[l]   = {stg_reg[s].q[l][PLAIN_W-2:0], 1'b1};
                end
                else
                begin
                    nxt.rem[l] = sh[l][D_W-1:0];
                    nxt.q[l]   = {stg_reg[s].q[l][PLAIN_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stg_reg[s+1] <= nxt;
        end
    end

    // Advance valid bits, stall all together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DIV_STEPS-1:0], !stat.empty};
            out_valid_reg <= vld_reg[DIV_STEPS];
        end
    end

    // Apply sign and singular override
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (stg_reg[DIV_STEPS].sing)
                    p_reg[k] <= '0;
                else if (stg_reg[DIV_STEPS].neg[k])
                    p_reg[k] <= -stg_reg[DIV_STEPS].q[k];
                else
                    p_reg[k] <= stg_reg[DIV_STEPS].q[k];
            end
            sing_reg <= stg_reg[DIV_STEPS].sing;
            last_reg <= stg_reg[DIV_STEPS].last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign plain_first  = p_reg[0];
    assign plain_second = p_reg[1];
    assign plain_third  = p_reg[2];
    assign singular_key = sing_reg;
    assign last_out     = last_reg;

endmodule

// ===== src/hill_cipher_block_decrypt.sv =====
// Path from input beat to result beat: 3 front stages, queue, 1 load stage,
//   39 divider stages, output register.
// Throughput: one block per cycle; the 8-entry queue credit sets input stall.
// The 39-stage restoring divider (one quotient bit per stage) sets the latency.
// Reset: rst_n asynchronous active low clears key registers to zero and empties
//   the pipeline and queue; no result is shown until a block is accepted.
module hill_cipher_block_decrypt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [hcbd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hcbd_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [hcbd_pkg::CIPH_W-1:0]  cipher_first,
    input  logic [hcbd_pkg::CIPH_W-1:0]  cipher_second,
    input  logic [hcbd_pkg::CIPH_W-1:0]  cipher_third,
    input  logic                         last_block,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [hcbd_pkg::PLAIN_W-1:0] plain_first,
    output logic [hcbd_pkg::PLAIN_W-1:0] plain_second,
    output logic [hcbd_pkg::PLAIN_W-1:0] plain_third,
    output logic                         singular_key,
    output logic                         last_out
);
    import hcbd_pkg::*;

    logic              take, push, pop;
    q_entry_t          entry, head;
    q_stat_t           stat;
    logic [FCNT_W-1:0] front_cnt;

    // Stall input once queued plus in-flight beats fill the queue
    assign in_stall = ({1'b0, stat.count} + (QCNT_W+1)'(front_cnt)) >= (QCNT_W+1)'(QDEPTH);
    assign take     = in_valid && !in_stall;

    hcbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .c0        (cipher_first),
        .c1        (cipher_second),
        .c2        (cipher_third),
        .last      (last_block),
        .push      (push),
        .entry     (entry),
        .front_cnt (front_cnt)
    );

    hcbd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (entry),
        .pop   (pop),
        .rdata (head),
        .stat  (stat)
    );

    hcbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .stat         (stat),
        .pop          (pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .plain_first  (plain_first),
        .plain_second (plain_second),
        .plain_third  (plain_third),
        .singular_key (singular_key),
        .last_out     (last_out)
    );

endmodule

// ===== src/hcbd_checker.sv =====
module hcbd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_write,
    input logic [hcbd_pkg::IDX_W-1:0]   cfg_index,
    input logic [hcbd_pkg::CFG_W-1:0]   cfg_data,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [hcbd_pkg::CIPH_W-1:0]  cipher_first,
    input logic [hcbd_pkg::CIPH_W-1:0]  cipher_second,
    input logic [hcbd_pkg::CIPH_W-1:0]  cipher_third,
    input logic                         last_block,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [hcbd_pkg::PLAIN_W-1:0] plain_first,
    input logic [hcbd_pkg::PLAIN_W-1:0] plain_second,
    input logic [hcbd_pkg::PLAIN_W-1:0] plain_third,
    input logic                         singular_key,
    input logic                         last_out
);
    import hcbd_pkg::*;

    logic [LEN_W-1:0] len_reg;

    // Track key length from the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (cfg_write && cfg_index == REG_KEY_LENGTH)
            len_reg <= cfg_data[LEN_W-1:0];
    end

    // Stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(plain_first)
            && $stable(plain_second) && $stable(plain_third)
            && $stable(singular_key) && $stable(last_out))
        else $error("result beat changed while stalled");

    // Singular key zeroes every character
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular_key |-> plain_first == '0 && plain_second == '0
            && plain_third == '0)
        else $error("singular result carries nonzero characters");

    // 2x2 key leaves third character zero
    a_small_third: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && len_reg <= KEY_SMALL_MAX |-> plain_third == '0)
        else $error("third character nonzero with 2x2 key");

    // Empty key is always singular
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && len_reg == '0 |-> singular_key)
        else $error("zero key length not flagged singular");

endmodule

bind hill_cipher_block_decrypt hcbd_checker u_hcbd_checker (.*);
